### rtl/core/sbtd_pkg.sv
package sbtd_pkg;

    localparam int NUM_BANDS       = 6;
    localparam int MAX_BINS        = 65536;
    localparam int COMPONENT_WIDTH = 24;

    localparam int CFG_W       = 16;
    localparam int NUM_REGS    = 7;
    localparam int CFG_IDX_W   = $clog2(NUM_REGS);
    localparam int BIN_W       = $clog2(MAX_BINS);

    localparam int SUM_W       = 41;
    localparam int AVG_W       = 25;
    localparam int THR_W       = 26;
    localparam int CNT_W       = $clog2(NUM_BANDS + 1);

    localparam int ROOT_W      = COMPONENT_WIDTH;
    localparam int RAD_W       = 2 * COMPONENT_WIDTH;
    localparam int REM_W       = ROOT_W + 3;
    localparam int MAG_W       = ROOT_W + 1;

    localparam int NCNT_W      = CFG_W + 1;
    localparam int DVD_W       = SUM_W + 1;
    localparam int PROD_W      = SUM_W + NCNT_W;
    localparam int STEP_W      = $clog2(DVD_W + 1);
    localparam int BOUND_W     = CFG_W + $clog2(NUM_BANDS + 1);
    localparam int BAND_IDX_W  = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

    localparam int PIPE_D      = 3 + ROOT_W;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] RST_BAND_START       = 16'd1501;
    localparam logic [CFG_W-1:0] RST_BAND_LENGTH      = 16'd201;
    localparam logic [CFG_W-1:0] RST_BAND_END         = 16'd2708;
    localparam logic [CFG_W-1:0] RST_NOISE_LOW_START  = 16'd308;
    localparam logic [CFG_W-1:0] RST_NOISE_LOW_END    = 16'd1049;
    localparam logic [CFG_W-1:0] RST_NOISE_HIGH_START = 16'd3879;
    localparam logic [CFG_W-1:0] RST_NOISE_HIGH_END   = 16'd6174;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BAND_START       = 3'd0,
        REG_BAND_LENGTH      = 3'd1,
        REG_BAND_END         = 3'd2,
        REG_NOISE_LOW_START  = 3'd3,
        REG_NOISE_LOW_END    = 3'd4,
        REG_NOISE_HIGH_START = 3'd5,
        REG_NOISE_HIGH_END   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_W-1:0] band_start;
        logic [CFG_W-1:0] band_length;
        logic [CFG_W-1:0] band_end;
        logic [CFG_W-1:0] noise_low_start;
        logic [CFG_W-1:0] noise_low_end;
        logic [CFG_W-1:0] noise_high_start;
        logic [CFG_W-1:0] noise_high_end;
    } t_cfg;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] bin_real;
        logic signed [COMPONENT_WIDTH-1:0] bin_imag;
        logic                              last_bin;
    } t_bin_req;

    typedef struct packed {
        logic [AVG_W-1:0]     band_avg_0;
        logic [AVG_W-1:0]     band_avg_1;
        logic [AVG_W-1:0]     band_avg_2;
        logic [AVG_W-1:0]     band_avg_3;
        logic [AVG_W-1:0]     band_avg_4;
        logic [AVG_W-1:0]     band_avg_5;
        logic [THR_W-1:0]     noise_threshold;
        logic [NUM_BANDS-1:0] detected_mask;
        logic [CNT_W-1:0]     detected_count;
    } t_result;

    typedef struct packed {
        logic [NUM_BANDS-1:0][SUM_W-1:0] band_sum;
        logic [SUM_W-1:0]                noise_sum;
    } t_frame_sums;

    typedef struct packed {
        logic               not_empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

### rtl/core/sbtd_front.sv
module sbtd_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  sbtd_pkg::t_bin_req   i_req,
    input  sbtd_pkg::t_cfg       i_cfg,
    input  sbtd_pkg::t_q_stat    i_q_stat,
    output logic                 o_busy,
    output logic                 o_push,
    output sbtd_pkg::t_frame_sums o_push_data
);
    import sbtd_pkg::*;

    typedef struct packed {
        logic                 valid;
        logic                 last;
        logic [1:0]           noise_hits;
        logic [NUM_BANDS-1:0] band_hits;
    } t_tag;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [MAG_W:0]   b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + (SUM_W + 1)'(b);
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

    logic                 w_accept;
    t_tag                 n_tag0;
    t_tag                 w_tail;
    logic [MAG_W-1:0]     w_mag;
    logic [MAG_W:0]       w_noise_add;
    logic [Q_CNT_W:0]     w_occupied;

    logic [BIN_W-1:0]     r_bin_cnt;
    logic [Q_CNT_W-1:0]   r_inflight;
    t_tag                 r_tag [PIPE_D];
    logic [ROOT_W-1:0]    r_abs_re;
    logic [ROOT_W-1:0]    r_abs_im;
    logic [RAD_W-1:0]     r_sq_re;
    logic [RAD_W-1:0]     r_sq_im;
    logic [RAD_W-1:0]     r_rad0;
    logic [RAD_W-1:0]     r_rad  [ROOT_W-1];
    logic [REM_W-1:0]     r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0]    r_root [ROOT_W];
    logic [SUM_W-1:0]     r_band_sum [NUM_BANDS];
    logic [SUM_W-1:0]     n_band_sum [NUM_BANDS];
    logic [SUM_W-1:0]     r_noise_sum;
    logic [SUM_W-1:0]     n_noise_sum;

    assign w_occupied = (Q_CNT_W + 1)'(i_q_stat.count) + (Q_CNT_W + 1)'(r_inflight);
    assign o_busy     = w_occupied >= (Q_CNT_W + 1)'(Q_DEPTH);
    assign w_accept   = i_start && !o_busy;

    // bin classification against the current counter
    always_comb begin
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        logic [BOUND_W-1:0] idx;
        idx = BOUND_W'(r_bin_cnt);
        n_tag0.valid = w_accept;
        n_tag0.last  = i_req.last_bin;
        n_tag0.noise_hits[0] = (r_bin_cnt >= i_cfg.noise_low_start)
                            && (r_bin_cnt <  i_cfg.noise_low_end);
        n_tag0.noise_hits[1] = (r_bin_cnt >= i_cfg.noise_high_start)
                            && (r_bin_cnt <  i_cfg.noise_high_end);
        for (int k = 0; k < NUM_BANDS; k++) begin
            lo = BOUND_W'(i_cfg.band_start) + BOUND_W'(k) * BOUND_W'(i_cfg.band_length);
            hi = (k == NUM_BANDS - 1) ? BOUND_W'(i_cfg.band_end)
                                      : lo + BOUND_W'(i_cfg.band_length);
            n_tag0.band_hits[k] = (idx >= lo) && (idx < hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < PIPE_D; j++) begin
                r_tag[j] <= '0;
            end
        end else begin
            r_tag[0] <= n_tag0;
            for (int j = 1; j < PIPE_D; j++) begin
                r_tag[j] <= r_tag[j-1];
            end
        end
    end

    // magnitude front: abs, squares, sum of squares
    always_ff @(posedge i_clk) begin
        r_abs_re <= i_req.bin_real[COMPONENT_WIDTH-1] ? ROOT_W'(-i_req.bin_real)
                                                      : ROOT_W'(i_req.bin_real);
        r_abs_im <= i_req.bin_imag[COMPONENT_WIDTH-1] ? ROOT_W'(-i_req.bin_imag)
                                                      : ROOT_W'(i_req.bin_imag);
        r_sq_re  <= RAD_W'(r_abs_re) * RAD_W'(r_abs_re);
        r_sq_im  <= RAD_W'(r_abs_im) * RAD_W'(r_abs_im);
        r_rad0   <= r_sq_re + r_sq_im;
    end

    // square root, one result bit per stage
    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = r_rad0;
        end else begin : g_next
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign rad_in  = r_rad[i-1];
        end

        assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            r_root[i] <= {root_in[ROOT_W-2:0], ge};
        end

        if (i < ROOT_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[i] <= ge ? rem_sh - trial : rem_sh;
                r_rad[i] <= rad_in << 2;
            end
        end
    end

    // accumulation
    assign w_tail = r_tag[PIPE_D-1];
    assign w_mag  = {r_root[ROOT_W-1], 1'b0};

    always_comb begin
        unique case (w_tail.noise_hits)
            2'b11:   w_noise_add = {w_mag, 1'b0};
            2'b01,
            2'b10:   w_noise_add = {1'b0, w_mag};
            default: w_noise_add = '0;
        endcase
        n_noise_sum = sat_add(r_noise_sum, w_noise_add);
        for (int k = 0; k < NUM_BANDS; k++) begin
            n_band_sum[k] = w_tail.band_hits[k] ? sat_add(r_band_sum[k], {1'b0, w_mag})
                                                : r_band_sum[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_tail.valid && w_tail.last)) begin
            r_noise_sum <= '0;
            for (int k = 0; k < NUM_BANDS; k++) begin
                r_band_sum[k] <= '0;
            end
        end else if (w_tail.valid) begin
            r_noise_sum <= n_noise_sum;
            for (int k = 0; k < NUM_BANDS; k++) begin
                r_band_sum[k] <= n_band_sum[k];
            end
        end
    end

    assign o_push = w_tail.valid && w_tail.last;

    always_comb begin
        o_push_data.noise_sum = n_noise_sum;
        for (int k = 0; k < NUM_BANDS; k++) begin
            o_push_data.band_sum[k] = n_band_sum[k];
        end
    end

    // bin counter and frame ends still in the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt  <= '0;
            r_inflight <= '0;
        end else begin
            if (w_accept) begin
                r_bin_cnt <= i_req.last_bin ? '0 : r_bin_cnt + 1'b1;
            end
            r_inflight <= r_inflight + Q_CNT_W'(w_accept && i_req.last_bin)
                                     - Q_CNT_W'(o_push);
        end
    end

endmodule

### rtl/core/sbtd_queue.sv
module sbtd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sbtd_pkg::t_frame_sums i_push_data,
    input  logic                  i_pop,
    output sbtd_pkg::t_frame_sums o_pop_data,
    output sbtd_pkg::t_q_stat     o_stat
);
    import sbtd_pkg::*;

    t_frame_sums        r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr_ptr;
    logic [Q_AW-1:0]    r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    assign o_pop_data       = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.count     = r_count;

endmodule

### rtl/core/sbtd_back.sv
module sbtd_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sbtd_pkg::t_cfg        i_cfg,
    input  sbtd_pkg::t_q_stat     i_q_stat,
    input  sbtd_pkg::t_frame_sums i_q_data,
    output logic                  o_pop,
    output logic                  o_res_valid,
    output sbtd_pkg::t_result     o_res
);
    import sbtd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RHS  = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    function automatic logic [CFG_W-1:0] span(input logic [CFG_W-1:0] lo,
                                              input logic [CFG_W-1:0] hi);
        return (hi > lo) ? hi - lo : '0;
    endfunction

    t_state               r_state;
    t_frame_sums          r_work;
    logic [NCNT_W-1:0]    r_ncount;
    logic [NCNT_W-1:0]    r_div;
    logic [NCNT_W-1:0]    r_rem;
    logic [DVD_W-1:0]     r_dvd;
    logic [STEP_W-1:0]    r_step;
    logic [PROD_W-1:0]    r_lhs;
    logic [PROD_W-1:0]    r_rhs;
    logic [BAND_IDX_W-1:0] r_band;
    logic                 r_is_thr;
    logic [AVG_W-1:0]     r_avg [NUM_BANDS];
    logic [THR_W-1:0]     r_thr;
    logic [NUM_BANDS-1:0] r_mask;
    logic                 r_res_valid;

    logic [NCNT_W-1:0]    w_ncount;
    logic [NCNT_W:0]      w_rem_sh;
    logic                 w_ge;
    logic [NCNT_W-1:0]    n_rem;
    logic [DVD_W-1:0]     n_dvd;
    logic                 w_blen_ok;
    logic [CNT_W-1:0]     w_cnt;

    assign w_ncount  = NCNT_W'(span(i_cfg.noise_low_start, i_cfg.noise_low_end))
                     + NCNT_W'(span(i_cfg.noise_high_start, i_cfg.noise_high_end));
    assign w_blen_ok = (i_cfg.band_length != '0);
    assign o_pop     = (r_state == S_IDLE) && i_q_stat.not_empty;

    // restoring divider, one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_div};
    assign n_rem    = w_ge ? NCNT_W'(w_rem_sh - {1'b0, r_div}) : NCNT_W'(w_rem_sh);
    assign n_dvd    = {r_dvd[DVD_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_RHS;
                    end
                end
                S_RHS: begin
                    r_state <= S_DIV;
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == STEP_W'(1)) begin
                        if (!r_is_thr && r_band == BAND_IDX_W'(NUM_BANDS - 1)) begin
                            r_res_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_work   <= i_q_data;
                r_ncount <= w_ncount;
            end
            S_RHS: begin
                r_rhs    <= PROD_W'({r_work.noise_sum, 1'b0}) * PROD_W'(i_cfg.band_length);
                r_dvd    <= {r_work.noise_sum, 1'b0};
                r_rem    <= '0;
                r_div    <= r_ncount;
                r_step   <= STEP_W'(DVD_W);
                r_is_thr <= 1'b1;
                r_band   <= '0;
            end
            S_MUL: begin
                r_lhs    <= PROD_W'(r_work.band_sum[r_band]) * PROD_W'(r_ncount);
                r_dvd    <= DVD_W'(r_work.band_sum[r_band]);
                r_rem    <= '0;
                r_div    <= NCNT_W'(i_cfg.band_length);
                r_step   <= STEP_W'(DVD_W);
                r_is_thr <= 1'b0;
            end
            S_DIV: begin
                r_dvd  <= n_dvd;
                r_rem  <= n_rem;
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    if (r_is_thr) begin
                        if (r_ncount == '0) begin
                            r_thr <= '0;
                        end else begin
                            r_thr <= (|n_dvd[DVD_W-1:THR_W]) ? {THR_W{1'b1}}
                                                             : n_dvd[THR_W-1:0];
                        end
                    end else begin
                        if (!w_blen_ok) begin
                            r_avg[r_band] <= '0;
                        end else begin
                            r_avg[r_band] <= (|n_dvd[DVD_W-1:AVG_W]) ? {AVG_W{1'b1}}
                                                                     : n_dvd[AVG_W-1:0];
                        end
                        r_mask[r_band] <= w_blen_ok && (r_ncount != '0) && (r_lhs >= r_rhs);
                        r_band         <= r_band + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < NUM_BANDS; k++) begin
            w_cnt = w_cnt + CNT_W'(r_mask[k]);
        end
    end

    assign o_res_valid            = r_res_valid;
    assign o_res.band_avg_0       = r_avg[0];
    assign o_res.band_avg_1       = r_avg[1];
    assign o_res.band_avg_2       = r_avg[2];
    assign o_res.band_avg_3       = r_avg[3];
    assign o_res.band_avg_4       = r_avg[4];
    assign o_res.band_avg_5       = r_avg[5];
    assign o_res.noise_threshold  = r_thr;
    assign o_res.detected_mask    = r_mask;
    assign o_res.detected_count   = w_cnt;

endmodule

### rtl/core/spectral_band_threshold_detector_core.sv
// channel   direction  handshake                 payload
// bins      in         i_start && !o_busy        i_req (bin_real, bin_imag, last_bin)
// results   out        o_res_valid, one cycle    o_res (averages, threshold, mask, count)
// config    in         i_cfg_we                  i_cfg_idx, i_cfg_data
//
// one bin per cycle while o_busy is low; magnitude pipe is 27 stages deep
// frame end: the threshold and the six band averages go in turn through the shared bit-serial divider
// o_busy rises while two frame ends are queued or still in the magnitude pipe
// the result strobe cannot be held off; reset clears counters, sums and queue
module spectral_band_threshold_detector_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  sbtd_pkg::t_bin_req               i_req,
    output logic                             o_busy,
    input  logic                             i_cfg_we,
    input  logic [sbtd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbtd_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_res_valid,
    output sbtd_pkg::t_result                o_res
);
    import sbtd_pkg::*;

    t_cfg        r_cfg;
    logic        w_push;
    logic        w_pop;
    t_frame_sums w_push_data;
    t_frame_sums w_pop_data;
    t_q_stat     w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_start       <= RST_BAND_START;
            r_cfg.band_length      <= RST_BAND_LENGTH;
            r_cfg.band_end         <= RST_BAND_END;
            r_cfg.noise_low_start  <= RST_NOISE_LOW_START;
            r_cfg.noise_low_end    <= RST_NOISE_LOW_END;
            r_cfg.noise_high_start <= RST_NOISE_HIGH_START;
            r_cfg.noise_high_end   <= RST_NOISE_HIGH_END;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BAND_START:       r_cfg.band_start       <= i_cfg_data;
                REG_BAND_LENGTH:      r_cfg.band_length      <= i_cfg_data;
                REG_BAND_END:         r_cfg.band_end         <= i_cfg_data;
                REG_NOISE_LOW_START:  r_cfg.noise_low_start  <= i_cfg_data;
                REG_NOISE_LOW_END:    r_cfg.noise_low_end    <= i_cfg_data;
                REG_NOISE_HIGH_START: r_cfg.noise_high_start <= i_cfg_data;
                REG_NOISE_HIGH_END:   r_cfg.noise_high_end   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbtd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_req       (i_req),
        .i_cfg       (r_cfg),
        .i_q_stat    (w_q_stat),
        .o_busy      (o_busy),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    sbtd_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_stat      (w_q_stat)
    );

    sbtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (w_q_stat),
        .i_q_data    (w_pop_data),
        .o_pop       (w_pop),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

### rtl/core/sbtd_checker.sv
module sbtd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  sbtd_pkg::t_bin_req i_req,
    input  logic               o_busy,
    input  logic               o_res_valid,
    input  sbtd_pkg::t_result  o_res
);

    // one frame end cannot produce back-to-back strobes
    a_res_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held longer than one cycle");

    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.detected_count == $countones(o_res.detected_mask)))
        else $error("detected count does not match mask");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res_valid && !o_busy))
        else $error("outputs active right after reset");

    // busy only rises after a frame end request was taken
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start && !o_busy && i_req.last_bin))
        else $error("busy rose without an accepted last bin");

endmodule

bind spectral_band_threshold_detector_core sbtd_checker u_sbtd_checker (.*);

### test/sbtd_frame_checker.sv
module sbtd_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  sbtd_pkg::t_bin_req              i_req,
    input  logic                            i_busy,
    input  logic                            i_cfg_we,
    input  logic [sbtd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sbtd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_res_valid,
    input  sbtd_pkg::t_result               i_res,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);
    import sbtd_pkg::*;

    localparam logic [63:0] SUM_CAP = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] AVG_CAP = (64'd1 << AVG_W) - 64'd1;
    localparam logic [63:0] THR_CAP = (64'd1 << THR_W) - 64'd1;

    t_cfg             regs;
    logic [BIN_W-1:0] bin_idx;
    logic [63:0]      band_acc [NUM_BANDS];
    logic [63:0]      noise_acc;
    t_result          frame_verdicts [$];
    t_result          want;
    int               mismatches = 0;
    int               compared = 0;
    int               owed = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = owed;
    assign o_checked    = compared;

    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] capped_sum(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s > SUM_CAP) ? SUM_CAP : s;
    endfunction

    function automatic logic [63:0] span_of(input logic [CFG_W-1:0] lo,
                                            input logic [CFG_W-1:0] hi);
        return (hi > lo) ? 64'(hi - lo) : 64'd0;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("error at %0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp);
        if (got !== exp) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, exp));
    endtask

    task automatic clear_frame();
        bin_idx = '0;
        noise_acc = '0;
        for (int k = 0; k < NUM_BANDS; k++) band_acc[k] = '0;
    endtask

    task automatic accumulate_bin(input t_bin_req b);
        longint               re;
        longint               im;
        logic [63:0]          mag;
        logic [63:0]          lo;
        logic [63:0]          hi;
        logic [63:0]          ncnt;
        logic [63:0]          thr;
        logic [63:0]          avg;
        logic [NUM_BANDS-1:0] mask;
        logic [CNT_W-1:0]     hits;
        logic [AVG_W-1:0]     avgs [NUM_BANDS];
        t_result              r;
        re = longint'(b.bin_real);
        im = longint'(b.bin_imag);
        if (re < 0) re = -re;
        if (im < 0) im = -im;
        mag = 64'd2 * floor_root(64'(re * re + im * im));

        if (bin_idx >= regs.noise_low_start && bin_idx < regs.noise_low_end)
            noise_acc = capped_sum(noise_acc, mag);
        if (bin_idx >= regs.noise_high_start && bin_idx < regs.noise_high_end)
            noise_acc = capped_sum(noise_acc, mag);
        for (int k = 0; k < NUM_BANDS; k++) begin
            lo = 64'(regs.band_start) + 64'(k) * 64'(regs.band_length);
            hi = (k == NUM_BANDS - 1) ? 64'(regs.band_end) : lo + 64'(regs.band_length);
            if (64'(bin_idx) >= lo && 64'(bin_idx) < hi) band_acc[k] = capped_sum(band_acc[k], mag);
        end
        bin_idx = bin_idx + 1'b1;
        if (!b.last_bin) return;

        ncnt = span_of(regs.noise_low_start, regs.noise_low_end)
             + span_of(regs.noise_high_start, regs.noise_high_end);
        thr = '0;
        if (ncnt != 0) begin
            thr = (64'd2 * noise_acc) / ncnt;
            if (thr > THR_CAP) thr = THR_CAP;
        end
        mask = '0;
        hits = '0;
        for (int k = 0; k < NUM_BANDS; k++) begin
            avg = '0;
            if (regs.band_length != 0) begin
                avg = band_acc[k] / 64'(regs.band_length);
                if (avg > AVG_CAP) avg = AVG_CAP;
                if (ncnt != 0 &&
                    band_acc[k] * ncnt >= 64'd2 * noise_acc * 64'(regs.band_length)) begin
                    mask[k] = 1'b1;
                    hits++;
                end
            end
            avgs[k] = avg[AVG_W-1:0];
        end
        r.band_avg_0      = avgs[0];
        r.band_avg_1      = avgs[1];
        r.band_avg_2      = avgs[2];
        r.band_avg_3      = avgs[3];
        r.band_avg_4      = avgs[4];
        r.band_avg_5      = avgs[5];
        r.noise_threshold = thr[THR_W-1:0];
        r.detected_mask   = mask;
        r.detected_count  = hits;
        frame_verdicts.push_back(r);
        clear_frame();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = {RST_BAND_START, RST_BAND_LENGTH, RST_BAND_END, RST_NOISE_LOW_START,
                    RST_NOISE_LOW_END, RST_NOISE_HIGH_START, RST_NOISE_HIGH_END};
            clear_frame();
            frame_verdicts.delete();
        end else begin
            if (i_res_valid !== 1'b0) begin
                if (frame_verdicts.size() == 0) begin
                    report_mismatch("result strobe with no frame end outstanding");
                end else begin
                    want = frame_verdicts.pop_front();
                    check_field("band_avg_0", 64'(i_res.band_avg_0), 64'(want.band_avg_0));
                    check_field("band_avg_1", 64'(i_res.band_avg_1), 64'(want.band_avg_1));
                    check_field("band_avg_2", 64'(i_res.band_avg_2), 64'(want.band_avg_2));
                    check_field("band_avg_3", 64'(i_res.band_avg_3), 64'(want.band_avg_3));
                    check_field("band_avg_4", 64'(i_res.band_avg_4), 64'(want.band_avg_4));
                    check_field("band_avg_5", 64'(i_res.band_avg_5), 64'(want.band_avg_5));
                    check_field("noise_threshold", 64'(i_res.noise_threshold),
                                64'(want.noise_threshold));
                    check_field("detected_mask", 64'(i_res.detected_mask),
                                64'(want.detected_mask));
                    check_field("detected_count", 64'(i_res.detected_count),
                                64'(want.detected_count));
                    compared++;
                end
            end
            // bin request accepted
            if (i_start && !i_busy) accumulate_bin(i_req);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BAND_START:       regs.band_start       = i_cfg_data;
                    REG_BAND_LENGTH:      regs.band_length      = i_cfg_data;
                    REG_BAND_END:         regs.band_end         = i_cfg_data;
                    REG_NOISE_LOW_START:  regs.noise_low_start  = i_cfg_data;
                    REG_NOISE_LOW_END:    regs.noise_low_end    = i_cfg_data;
                    REG_NOISE_HIGH_START: regs.noise_high_start = i_cfg_data;
                    REG_NOISE_HIGH_END:   regs.noise_high_end   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        owed = frame_verdicts.size();
    end

endmodule

### test/spectral_band_threshold_detector_core_test.sv
module spectral_band_threshold_detector_core_test;
    import sbtd_pkg::*;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 11;
    localparam int SETTLE_CYCLES     = 400;
    localparam int DRAIN_LIMIT       = 5000;
    localparam int RUN_LIMIT_CYCLES  = 3_000_000;
    localparam int BIN_TARGET        = 700;
    localparam int FRAME_TARGET      = 20;
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = CFG_IDX_W'(NUM_REGS);
    localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MIN =
        {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
    localparam logic signed [COMPONENT_WIDTH-1:0] COMP_MAX =
        {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_bin_req             i_req = '0;
    logic                 o_busy;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_res_valid;
    t_result              o_res;

    int fail_count;
    int pending;
    int checked;
    int bins_sent = 0;
    int frames_sent = 0;
    int settings_used = 0;
    bit steady = 1'b0;

    spectral_band_threshold_detector_core dut (
        .i_clk, .i_rst_n, .i_start, .i_req, .o_busy,
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_res_valid, .o_res
    );

    sbtd_frame_checker frame_check (
        .i_clk, .i_rst_n, .i_start, .i_req,
        .i_busy       (o_busy),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_res_valid  (o_res_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_cfg make_settings(
        input logic [CFG_W-1:0] bs, input logic [CFG_W-1:0] bl, input logic [CFG_W-1:0] be,
        input logic [CFG_W-1:0] nls, input logic [CFG_W-1:0] nle,
        input logic [CFG_W-1:0] nhs, input logic [CFG_W-1:0] nhe);
        return {bs, bl, be, nls, nle, nhs, nhe};
    endfunction

    function automatic logic signed [COMPONENT_WIDTH-1:0] random_component();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 5))
            0: return COMP_MIN;
            1: return COMP_MAX;
            2: return {COMPONENT_WIDTH{raw[31]}};
            3: return COMPONENT_WIDTH'($signed(raw[8:0]));
            default: return raw[COMPONENT_WIDTH-1:0];
        endcase
    endfunction

    task automatic send_bin(input logic signed [COMPONENT_WIDTH-1:0] re,
                            input logic signed [COMPONENT_WIDTH-1:0] im,
                            input logic last);
        int                        gap;
        logic [$bits(t_bin_req)-1:0] junk;
        gap = steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            junk = $bits(t_bin_req)'({$urandom, $urandom});
            @(negedge i_clk);
            i_start <= 1'b0;
            i_req <= junk;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start <= 1'b1;
        i_req <= {re, im, last};
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        bins_sent++;
        if (last) frames_sent++;
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) send_bin(random_component(), random_component(), i == len - 1);
    endtask

    task automatic drain(input int extra);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        t_reg_idx r;
        r = r.first();
        do begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= r;
            case (r)
                REG_BAND_START:       i_cfg_data <= c.band_start;
                REG_BAND_LENGTH:      i_cfg_data <= c.band_length;
                REG_BAND_END:         i_cfg_data <= c.band_end;
                REG_NOISE_LOW_START:  i_cfg_data <= c.noise_low_start;
                REG_NOISE_LOW_END:    i_cfg_data <= c.noise_low_end;
                REG_NOISE_HIGH_START: i_cfg_data <= c.noise_high_start;
                REG_NOISE_HIGH_END:   i_cfg_data <= c.noise_high_end;
                default: ;
            endcase
            r = r.next();
        end while (r != r.first());
        // unmapped index must be ignored
        @(negedge i_clk);
        i_cfg_idx <= SPARE_REG_IDX;
        i_cfg_data <= CFG_W'($urandom);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int random_bins;
        int results_before;
        int phase_bins;
        int len;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, frame reaching past the lower noise range
        steady = 1'b1;
        send_frame(RST_NOISE_LOW_END + 8);
        drain(SETTLE_CYCLES);

        // overlapping noise ranges, short bands, component extremes
        apply_settings(make_settings(1, 2, 12, 0, 3, 2, 5));
        steady = 1'b0;
        send_bin(COMP_MIN, COMP_MIN, 1'b0);
        send_bin(COMP_MAX, COMP_MAX, 1'b0);
        send_bin(0, 0, 1'b0);
        send_bin(COMP_MIN, COMP_MAX, 1'b0);
        send_bin(COMP_MAX, COMP_MIN, 1'b0);
        send_bin(0, COMP_MIN, 1'b0);
        send_bin(-1, 1, 1'b0);
        send_bin(COMP_MAX, 0, 1'b0);
        send_bin(3, 4, 1'b0);
        send_bin(COMP_MIN, 0, 1'b0);
        send_bin(0, COMP_MAX, 1'b0);
        send_bin(5, -12, 1'b0);
        send_bin(COMP_MIN, COMP_MIN, 1'b1);
        send_bin(COMP_MAX, COMP_MIN, 1'b1);
        drain(SETTLE_CYCLES);

        // zero band length
        apply_settings(make_settings(1, 0, 12, 0, 3, 2, 5));
        send_frame(5);
        drain(SETTLE_CYCLES);

        // empty and reversed noise ranges
        apply_settings(make_settings(0, 2, 12, 9, 4, 7, 7));
        send_frame(5);
        drain(SETTLE_CYCLES);

        apply_settings(make_settings('1, '1, '1, '1, '1, '1, '1));
        send_frame(20);
        drain(SETTLE_CYCLES);
        apply_settings(make_settings('0, '0, '0, '0, '0, '0, '0));
        send_frame(20);
        drain(SETTLE_CYCLES);

        // saturating band average in a wide last band
        apply_settings(make_settings(0, 1, 8, 0, 2, 1, 3));
        for (int i = 0; i < 8; i++) send_bin(COMP_MIN, COMP_MIN, i == 7);
        drain(SETTLE_CYCLES);

        random_bins = 0;
        results_before = checked;
        while (random_bins < BIN_TARGET || checked < results_before + FRAME_TARGET) begin
            apply_settings(make_settings(CFG_W'($urandom_range(0, 20)),
                ($urandom_range(0, 7) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 10)),
                CFG_W'($urandom_range(0, 80)), CFG_W'($urandom_range(0, 40)),
                CFG_W'($urandom_range(0, 70)), CFG_W'($urandom_range(0, 70)),
                CFG_W'($urandom_range(0, 80))));
            phase_bins = $urandom_range(120, 260);
            while (phase_bins > 0) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 70);
                steady = ($urandom_range(0, 3) == 0);
                send_frame(len);
                phase_bins -= len;
                random_bins += len;
                if ($urandom_range(0, 19) == 0) drain(0);
            end
            drain(SETTLE_CYCLES);
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        for (int w = 0; w < DRAIN_LIMIT && pending != 0; w++) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("drove %0d bins in %0d frames across %0d register settings",
                 bins_sent, frames_sent, settings_used);
        $display("%0d frame results compared, %0d never arrived", checked, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("spectral_band_threshold_detector_core: match");
        end else begin
            $display("spectral_band_threshold_detector_core: mismatch");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * RUN_LIMIT_CYCLES);
        $display("spectral_band_threshold_detector_core: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sbtd_pkg.sv
rtl/core/sbtd_front.sv
rtl/core/sbtd_queue.sv
rtl/core/sbtd_back.sv
rtl/core/spectral_band_threshold_detector_core.sv
rtl/core/sbtd_checker.sv
test/sbtd_frame_checker.sv
test/spectral_band_threshold_detector_core_test.sv
